FILE: hdl/brsp_pkg.sv
// Shared types and constants for the base relocation stream parser.
package brsp_pkg;

   // Default depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Directory layout constants.
   localparam logic [31:0] HEADER_BYTES = 32'd8;
   localparam logic [30:0] HEADER_HALVES = 31'd4;
   localparam logic [11:0] OFFSET_MASK = 12'h0FFF;
   localparam int TYPE_SHIFT = 12;
   localparam logic [3:0] TYPE_SKIP = 4'd0;
   localparam logic [3:0] TYPE_HIGHLOW = 4'd3;

   // Input operation codes.
   typedef enum logic {
      OP_START = 1'b0,
      OP_HALF  = 1'b1
   } op_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_FIXUP    = 2'd0,
      KIND_FINISHED = 2'd1,
      KIND_ERROR    = 2'd2
   } kind_type;

   // Error codes.
   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_NO_DIR   = 3'd1,
      ERR_TRUNC    = 3'd2,
      ERR_SIZE     = 3'd3,
      ERR_TYPE     = 3'd4,
      ERR_OVERFLOW = 3'd5
   } err_type;

   // Walker phases.
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_HDR0  = 3'd1,
      PH_HDR1  = 3'd2,
      PH_HDR2  = 3'd3,
      PH_HDR3  = 3'd4,
      PH_ENTRY = 3'd5,
      PH_DONE  = 3'd6,
      PH_FAIL  = 3'd7
   } phase_type;

   // Entry type classes, decoded in the front.
   typedef enum logic [1:0] {
      ENT_SKIP    = 2'd0,
      ENT_HIGHLOW = 2'd1,
      ENT_OTHER   = 2'd2
   } ent_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_LOAD_BASE  = 2'd0,
      REG_IMAGE_BASE = 2'd1,
      REG_DIR_OFFSET = 2'd2,
      REG_DIR_SIZE   = 2'd3
   } reg_index_type;

   // Input item.
   typedef struct packed {
      logic        op;
      logic [15:0] half_word;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] target_address;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // Classified item as it travels through the queue.
   typedef struct packed {
      logic        is_start;
      ent_type     ent;
      logic [15:0] half_word;
   } cls_type;

   // Configuration registers seen by the back.
   typedef struct packed {
      logic [31:0] place_base;
      logic [31:0] pref_base;
      logic [31:0] directory_offset;
      logic [31:0] directory_size;
   } cfg_type;

endpackage

FILE: hdl/brsp_front.sv
// Front stage: accepts input transfers and classifies each item.
module brsp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brsp_pkg::req_type req_payload,
   output logic              cls_valid,
   input  logic              cls_ready,
   output brsp_pkg::cls_type cls_item
);

   logic              valid_ff, valid_in;
   brsp_pkg::cls_type item_ff, item_in;
   logic [3:0]        etype;

   // The stage takes a new item whenever it is empty or its item moves on.
   assign req_ready = !valid_ff || cls_ready;
   assign etype = req_payload.half_word[15:brsp_pkg::TYPE_SHIFT];

   // Decode the operation and the entry type of the halfword.
   always_comb begin
      item_in.is_start = (req_payload.op == brsp_pkg::OP_START);
      item_in.half_word = req_payload.half_word;
      if (etype == brsp_pkg::TYPE_SKIP) begin
         item_in.ent = brsp_pkg::ENT_SKIP;
      end else if (etype == brsp_pkg::TYPE_HIGHLOW) begin
         item_in.ent = brsp_pkg::ENT_HIGHLOW;
      end else begin
         item_in.ent = brsp_pkg::ENT_OTHER;
      end
      valid_in = req_valid || (valid_ff && !cls_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_item = item_ff;

endmodule

FILE: hdl/brsp_queue.sv
// Small FIFO between the front and the back.
module brsp_queue #(
   parameter int Depth = brsp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  brsp_pkg::cls_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output brsp_pkg::cls_type pop_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   brsp_pkg::cls_type mem [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid = (count_ff != '0);
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_item = mem[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/brsp_back.sv
// Back stage: walks the directory one item per cycle unless stalled; registers the result.
module brsp_back (
   input  logic              clock,
   input  logic              reset,
   input  brsp_pkg::cfg_type cfg,
   input  logic              item_valid,
   output logic              item_ready,
   input  brsp_pkg::cls_type item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brsp_pkg::rsp_type rsp_payload
);

   brsp_pkg::phase_type phase_ff, phase_in;
   logic [15:0] page_lo_ff, page_lo_in;
   logic [31:0] page_ff, page_in;
   logic [15:0] blk_lo_ff, blk_lo_in;
   logic [31:0] consumed_ff, consumed_in;
   logic [30:0] entries_ff, entries_in;
   logic        rsp_valid_ff, rsp_valid_in;
   brsp_pkg::rsp_type rsp_ff, rsp_in;

   logic        fire, emit;
   logic [31:0] blk_len;
   logic [31:0] remain;
   logic [31:0] consumed_next;
   logic [33:0] dir_addr;
   logic [33:0] target;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign fire = item_valid && item_ready;
   assign blk_len = {item.half_word, blk_lo_ff};

   // Sums are formed from the live registers so that a register write takes effect at once.
   assign remain = cfg.directory_size - consumed_ff;
   assign consumed_next = consumed_ff + blk_len;
   assign dir_addr = {2'b00, cfg.place_base} + {2'b00, cfg.directory_offset}
                   + {2'b00, consumed_ff};
   assign target = {2'b00, cfg.place_base} + {2'b00, page_ff}
                 + {22'd0, item.half_word[11:0] & brsp_pkg::OFFSET_MASK};

   // Walker: next phase, running sums and the result of the current item.
   always_comb begin
      phase_in = phase_ff;
      page_lo_in = page_lo_ff;
      page_in = page_ff;
      blk_lo_in = blk_lo_ff;
      consumed_in = consumed_ff;
      entries_in = entries_ff;
      emit = 1'b0;
      rsp_in.kind = brsp_pkg::KIND_FINISHED;
      rsp_in.target_address = '0;
      rsp_in.error_code = brsp_pkg::ERR_NONE;
      rsp_in.last = 1'b1;
      if (item.is_start) begin
         // A start item checks the configuration and opens a pass.
         entries_in = '0;
         consumed_in = '0;
         if (cfg.place_base == cfg.pref_base) begin
            phase_in = brsp_pkg::PH_DONE;
            emit = 1'b1;
         end else if (cfg.directory_offset == '0 || cfg.directory_size == '0) begin
            phase_in = brsp_pkg::PH_FAIL;
            emit = 1'b1;
            rsp_in.kind = brsp_pkg::KIND_ERROR;
            rsp_in.error_code = brsp_pkg::ERR_NO_DIR;
         end else begin
            phase_in = brsp_pkg::PH_HDR0;
         end
      end else begin
         unique case (phase_ff)
            brsp_pkg::PH_HDR0: begin
               // Checks that come before a block header.
               if (remain < brsp_pkg::HEADER_BYTES) begin
                  phase_in = brsp_pkg::PH_FAIL;
                  emit = 1'b1;
                  rsp_in.kind = brsp_pkg::KIND_ERROR;
                  rsp_in.error_code = brsp_pkg::ERR_TRUNC;
               end else if (dir_addr[33:32] != 2'b00) begin
                  phase_in = brsp_pkg::PH_FAIL;
                  emit = 1'b1;
                  rsp_in.kind = brsp_pkg::KIND_ERROR;
                  rsp_in.error_code = brsp_pkg::ERR_OVERFLOW;
               end else begin
                  page_lo_in = item.half_word;
                  phase_in = brsp_pkg::PH_HDR1;
               end
            end
            brsp_pkg::PH_HDR1: begin
               page_in = {item.half_word, page_lo_ff};
               phase_in = brsp_pkg::PH_HDR2;
            end
            brsp_pkg::PH_HDR2: begin
               blk_lo_in = item.half_word;
               phase_in = brsp_pkg::PH_HDR3;
            end
            brsp_pkg::PH_HDR3: begin
               // Block size checks; the block is charged against the directory now.
               if (blk_len < brsp_pkg::HEADER_BYTES || blk_len > remain || blk_len[0]) begin
                  phase_in = brsp_pkg::PH_FAIL;
                  emit = 1'b1;
                  rsp_in.kind = brsp_pkg::KIND_ERROR;
                  rsp_in.error_code = brsp_pkg::ERR_SIZE;
               end else begin
                  consumed_in = consumed_next;
                  entries_in = blk_len[31:1] - brsp_pkg::HEADER_HALVES;
                  if (blk_len == brsp_pkg::HEADER_BYTES) begin
                     if (consumed_next >= cfg.directory_size) begin
                        phase_in = brsp_pkg::PH_DONE;
                        emit = 1'b1;
                     end else begin
                        phase_in = brsp_pkg::PH_HDR0;
                     end
                  end else begin
                     phase_in = brsp_pkg::PH_ENTRY;
                  end
               end
            end
            brsp_pkg::PH_ENTRY: begin
               if (item.ent == brsp_pkg::ENT_OTHER) begin
                  phase_in = brsp_pkg::PH_FAIL;
                  emit = 1'b1;
                  rsp_in.kind = brsp_pkg::KIND_ERROR;
                  rsp_in.error_code = brsp_pkg::ERR_TYPE;
               end else if (item.ent == brsp_pkg::ENT_HIGHLOW && target[33:32] != 2'b00) begin
                  phase_in = brsp_pkg::PH_FAIL;
                  emit = 1'b1;
                  rsp_in.kind = brsp_pkg::KIND_ERROR;
                  rsp_in.error_code = brsp_pkg::ERR_OVERFLOW;
               end else begin
                  entries_in = entries_ff - 1'b1;
                  if (item.ent == brsp_pkg::ENT_HIGHLOW) begin
                     emit = 1'b1;
                     rsp_in.kind = brsp_pkg::KIND_FIXUP;
                     rsp_in.target_address = target[31:0];
                     rsp_in.last = 1'b0;
                  end
                  // Last entry of the block: end of pass or next header.
                  if (entries_ff == 31'd1) begin
                     if (consumed_ff >= cfg.directory_size) begin
                        phase_in = brsp_pkg::PH_DONE;
                        emit = 1'b1;
                        rsp_in.last = 1'b1;
                     end else begin
                        phase_in = brsp_pkg::PH_HDR0;
                     end
                  end
               end
            end
            default: begin
               // Idle, finished or failed: the halfword is dropped.
            end
         endcase
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (fire && emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= brsp_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
         end
      end
   end

   // Walker payload registers.
   always_ff @(posedge clock) begin
      if (fire) begin
         page_lo_ff <= page_lo_in;
         page_ff <= page_in;
         blk_lo_ff <= blk_lo_in;
         consumed_ff <= consumed_in;
         entries_ff <= entries_in;
      end
      if (fire && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/base_relocation_stream_parser.sv
// Top level of the base relocation stream parser: register port and stage wiring.
//
// The req channel carries directory items: op 0 opens a pass and checks the
// load base, image base and directory registers; op 1 brings the next
// little-endian halfword of the directory. The rsp channel returns at most one
// result per item: a fixup target, a finished mark or an error, with last set
// on the final result of a pass. Errors hold until the next start.
// Registers are written over the APB-style port; the user must write them
// only while the block is idle, and the block itself does not enforce this.
// One item is taken per cycle unless req_ready is low. A result passes the
// classifying front register and the queue, and the walker then loads its
// output register. The walker handles one item per cycle while its output
// register is free, and its phase update sets the rate.
// When the receiver stalls, the output register holds its result, the queue
// fills behind it, and req_ready falls once the queue and front are full.
// Reset clears the registers to zero, empties the queue and returns the
// walker to idle; no clearing pass is needed.
module base_relocation_stream_parser #(
   parameter int QueueDepth = brsp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brsp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brsp_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   brsp_pkg::cfg_type cfg_ff;
   brsp_pkg::reg_index_type reg_index;
   logic              cls_valid, cls_ready;
   brsp_pkg::cls_type cls_item;
   logic              q_valid, q_ready;
   brsp_pkg::cls_type q_item;

   assign pready = 1'b1;
   assign reg_index = brsp_pkg::reg_index_type'(paddr[3:2]);

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (reg_index)
            brsp_pkg::REG_LOAD_BASE:  cfg_ff.place_base <= pwdata;
            brsp_pkg::REG_IMAGE_BASE: cfg_ff.pref_base <= pwdata;
            brsp_pkg::REG_DIR_OFFSET: cfg_ff.directory_offset <= pwdata;
            brsp_pkg::REG_DIR_SIZE:   cfg_ff.directory_size <= pwdata;
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_index)
         brsp_pkg::REG_LOAD_BASE:  prdata = cfg_ff.place_base;
         brsp_pkg::REG_IMAGE_BASE: prdata = cfg_ff.pref_base;
         brsp_pkg::REG_DIR_OFFSET: prdata = cfg_ff.directory_offset;
         brsp_pkg::REG_DIR_SIZE:   prdata = cfg_ff.directory_size;
         default:                  prdata = '0;
      endcase
   end

   brsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cls_valid   (cls_valid),
      .cls_ready   (cls_ready),
      .cls_item    (cls_item)
   );

   brsp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cls_valid),
      .push_ready (cls_ready),
      .push_item  (cls_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   brsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_valid  (q_valid),
      .item_ready  (q_ready),
      .item        (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: verif/base_relocation_stream_parser_tb.sv
// Self-checking testbench for the base relocation stream parser.
module base_relocation_stream_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Results trail their item via front, queue and output; idle waits allow a margin.
   localparam int PIPE_LATENCY = 3;
   localparam int RANDOM_ITEMS = 370;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TIMEOUT_NS = 4_000_000;
   localparam logic [33:0] ADDR_LIMIT = 34'h0_FFFF_FFFF;

   // One row of the directed table: a register write or an item transfer.
   typedef enum logic {
      ROW_WRITE,
      ROW_ITEM
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      brsp_pkg::reg_index_type idx;
      logic [31:0]             value;
      brsp_pkg::req_type       item;
      logic                    pinned;
      brsp_pkg::rsp_type       outcome;
   } dir_row_type;

   function automatic dir_row_type cfg_row(brsp_pkg::reg_index_type idx, logic [31:0] value);
      dir_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.idx = idx;
      r.value = value;
      return r;
   endfunction

   function automatic dir_row_type item_row(brsp_pkg::op_type op, logic [15:0] hw);
      dir_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.item = {op, hw};
      return r;
   endfunction

   // Rows whose result is fixed: errors and finished marks end the pass.
   function automatic dir_row_type pinned_row(brsp_pkg::op_type op, logic [15:0] hw,
                                              brsp_pkg::kind_type kind,
                                              brsp_pkg::err_type code);
      dir_row_type r;
      r = item_row(op, hw);
      r.pinned = 1'b1;
      r.outcome.kind = kind;
      r.outcome.target_address = '0;
      r.outcome.error_code = code;
      r.outcome.last = 1'b1;
      return r;
   endfunction

   localparam int DIRECTED_COUNT = 31;
   localparam dir_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Halfword before any start, then a start with equal bases.
      item_row(brsp_pkg::OP_HALF, 16'hFFFF),
      pinned_row(brsp_pkg::OP_START, 16'h0000, brsp_pkg::KIND_FINISHED, brsp_pkg::ERR_NONE),
      // Move needed but the directory size is still zero.
      cfg_row(brsp_pkg::REG_LOAD_BASE, 32'hFFFF_FFF8),
      cfg_row(brsp_pkg::REG_IMAGE_BASE, 32'h0040_0000),
      cfg_row(brsp_pkg::REG_DIR_OFFSET, 32'h0000_2000),
      pinned_row(brsp_pkg::OP_START, 16'h0000, brsp_pkg::KIND_ERROR, brsp_pkg::ERR_NO_DIR),
      // Directory address overflows on the first header halfword.
      cfg_row(brsp_pkg::REG_DIR_SIZE, 32'h0000_000E),
      item_row(brsp_pkg::OP_START, 16'hFFFF),
      pinned_row(brsp_pkg::OP_HALF, 16'hABCD, brsp_pkg::KIND_ERROR, brsp_pkg::ERR_OVERFLOW),
      // One fixup, then too few bytes left for another header.
      cfg_row(brsp_pkg::REG_LOAD_BASE, 32'h1000_0000),
      item_row(brsp_pkg::OP_START, 16'h0000),
      item_row(brsp_pkg::OP_HALF, 16'h1000),
      item_row(brsp_pkg::OP_HALF, 16'h0000),
      item_row(brsp_pkg::OP_HALF, 16'h000A),
      item_row(brsp_pkg::OP_HALF, 16'h0000),
      item_row(brsp_pkg::OP_HALF, 16'h3FFF),
      pinned_row(brsp_pkg::OP_HALF, 16'h1234, brsp_pkg::KIND_ERROR, brsp_pkg::ERR_TRUNC),
      // Block size below the header size.
      cfg_row(brsp_pkg::REG_DIR_SIZE, 32'hFFFF_FFFF),
      item_row(brsp_pkg::OP_START, 16'h0000),
      item_row(brsp_pkg::OP_HALF, 16'hF000),
      item_row(brsp_pkg::OP_HALF, 16'hFFFF),
      item_row(brsp_pkg::OP_HALF, 16'h0007),
      pinned_row(brsp_pkg::OP_HALF, 16'h0000, brsp_pkg::KIND_ERROR, brsp_pkg::ERR_SIZE),
      // Skipped entry, then a fixup target past the top of the address space.
      cfg_row(brsp_pkg::REG_DIR_SIZE, 32'h0000_0010),
      item_row(brsp_pkg::OP_START, 16'h0000),
      item_row(brsp_pkg::OP_HALF, 16'hF000),
      item_row(brsp_pkg::OP_HALF, 16'hFFFF),
      item_row(brsp_pkg::OP_HALF, 16'h000C),
      item_row(brsp_pkg::OP_HALF, 16'h0000),
      item_row(brsp_pkg::OP_HALF, 16'h0FFF),
      pinned_row(brsp_pkg::OP_HALF, 16'h3000, brsp_pkg::KIND_ERROR, brsp_pkg::ERR_OVERFLOW)
   };

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   brsp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   brsp_pkg::rsp_type rsp_payload;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [3:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   // Walker copy: registers and pass state as the block should hold them.
   logic [31:0]         m_load = '0;
   logic [31:0]         m_image = '0;
   logic [31:0]         m_dir_off = '0;
   logic [31:0]         m_dir_size = '0;
   brsp_pkg::phase_type m_phase = brsp_pkg::PH_IDLE;
   logic [31:0]         m_page = '0;
   logic [31:0]         m_blk_len = '0;
   logic [31:0]         m_consumed = '0;
   logic [31:0]         m_entries = '0;

   brsp_pkg::rsp_type reloc_results_q[$];
   int      mismatch_count = 0;
   int      items_sent = 0;
   int      live_items = 0;
   int      settings_count = 0;
   int      n_fixup = 0;
   int      n_finished = 0;
   int      n_error = 0;
   bit      sender_steady = 1'b0;
   bit      in_pass = 1'b0;

   base_relocation_stream_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic note_mismatch(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic brsp_pkg::rsp_type make_result(brsp_pkg::kind_type kind,
                                                     logic [31:0] target,
                                                     brsp_pkg::err_type code, logic last);
      brsp_pkg::rsp_type r;
      r.kind = kind;
      r.target_address = target;
      r.error_code = code;
      r.last = last;
      return r;
   endfunction

   // Errors stop the pass until the next start.
   function automatic brsp_pkg::rsp_type fail_with(brsp_pkg::err_type code);
      m_phase = brsp_pkg::PH_FAIL;
      return make_result(brsp_pkg::KIND_ERROR, '0, code, 1'b1);
   endfunction

   // A block is complete: either the pass ends or the next header follows.
   function automatic bit close_block();
      m_consumed = m_consumed + m_blk_len;
      if (m_consumed >= m_dir_size) begin
         m_phase = brsp_pkg::PH_DONE;
         return 1'b1;
      end
      m_phase = brsp_pkg::PH_HDR0;
      return 1'b0;
   endfunction

   // Advance the walker copy by one accepted item; returns 1 when a result is due.
   function automatic bit walk_step(input brsp_pkg::req_type item,
                                    output brsp_pkg::rsp_type res);
      logic [33:0] sum;
      logic [3:0]  etype;
      bit          fix;
      res = '0;
      sum = '0;
      fix = 1'b0;
      if (item.op == brsp_pkg::OP_START) begin
         m_page = '0;
         m_blk_len = '0;
         m_consumed = '0;
         m_entries = '0;
         if (m_load == m_image) begin
            m_phase = brsp_pkg::PH_DONE;
            res = make_result(brsp_pkg::KIND_FINISHED, '0, brsp_pkg::ERR_NONE, 1'b1);
            return 1'b1;
         end
         if (m_dir_off == '0 || m_dir_size == '0) begin
            res = fail_with(brsp_pkg::ERR_NO_DIR);
            return 1'b1;
         end
         m_phase = brsp_pkg::PH_HDR0;
         return 1'b0;
      end
      case (m_phase)
         brsp_pkg::PH_HDR0: begin
            if (m_dir_size - m_consumed < brsp_pkg::HEADER_BYTES) begin
               res = fail_with(brsp_pkg::ERR_TRUNC);
               return 1'b1;
            end
            sum = 34'(m_load) + 34'(m_dir_off) + 34'(m_consumed);
            if (sum > ADDR_LIMIT) begin
               res = fail_with(brsp_pkg::ERR_OVERFLOW);
               return 1'b1;
            end
            m_page = {16'h0000, item.half_word};
            m_phase = brsp_pkg::PH_HDR1;
         end
         brsp_pkg::PH_HDR1: begin
            m_page[31:16] = item.half_word;
            m_phase = brsp_pkg::PH_HDR2;
         end
         brsp_pkg::PH_HDR2: begin
            m_blk_len = {16'h0000, item.half_word};
            m_phase = brsp_pkg::PH_HDR3;
         end
         brsp_pkg::PH_HDR3: begin
            m_blk_len[31:16] = item.half_word;
            // The entry area must be a whole number of halfwords.
            if (m_blk_len < brsp_pkg::HEADER_BYTES || m_blk_len > m_dir_size - m_consumed ||
                m_blk_len[0]) begin
               res = fail_with(brsp_pkg::ERR_SIZE);
               return 1'b1;
            end
            m_entries = (m_blk_len - brsp_pkg::HEADER_BYTES) >> 1;
            if (m_entries == '0) begin
               if (close_block()) begin
                  res = make_result(brsp_pkg::KIND_FINISHED, '0, brsp_pkg::ERR_NONE, 1'b1);
                  return 1'b1;
               end
            end else begin
               m_phase = brsp_pkg::PH_ENTRY;
            end
         end
         brsp_pkg::PH_ENTRY: begin
            etype = item.half_word[15:brsp_pkg::TYPE_SHIFT];
            if (etype == brsp_pkg::TYPE_HIGHLOW) begin
               sum = 34'(m_load) + 34'(m_page)
                   + 34'(item.half_word[brsp_pkg::TYPE_SHIFT-1:0]);
               if (sum > ADDR_LIMIT) begin
                  res = fail_with(brsp_pkg::ERR_OVERFLOW);
                  return 1'b1;
               end
               fix = 1'b1;
            end else if (etype != brsp_pkg::TYPE_SKIP) begin
               res = fail_with(brsp_pkg::ERR_TYPE);
               return 1'b1;
            end
            m_entries = m_entries - 32'd1;
            // The last entry of the final block carries the end of the pass.
            if (m_entries == '0 && close_block()) begin
               res = fix ? make_result(brsp_pkg::KIND_FIXUP, sum[31:0], brsp_pkg::ERR_NONE, 1'b1)
                         : make_result(brsp_pkg::KIND_FINISHED, '0, brsp_pkg::ERR_NONE, 1'b1);
               return 1'b1;
            end
            if (fix) begin
               res = make_result(brsp_pkg::KIND_FIXUP, sum[31:0], brsp_pkg::ERR_NONE, 1'b0);
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Offer one item and hold it until the transfer; then predict its result.
   task automatic send_item(brsp_pkg::req_type item, bit pinned, brsp_pkg::rsp_type outcome);
      brsp_pkg::rsp_type res;
      bit      has_res;
      int      gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (!(item.op == brsp_pkg::OP_HALF &&
            m_phase inside {brsp_pkg::PH_IDLE, brsp_pkg::PH_DONE, brsp_pkg::PH_FAIL})) begin
         live_items++;
      end
      has_res = walk_step(item, res);
      if (pinned) begin
         reloc_results_q.insert(reloc_results_q.size(), outcome);
      end else if (has_res) begin
         reloc_results_q.insert(reloc_results_q.size(), res);
      end
   endtask

   // Wait until every result is back and items without results have drained.
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (reloc_results_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 5) @(posedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic write_reg(brsp_pkg::reg_index_type idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         brsp_pkg::REG_LOAD_BASE:  m_load = value;
         brsp_pkg::REG_IMAGE_BASE: m_image = value;
         brsp_pkg::REG_DIR_OFFSET: m_dir_off = value;
         brsp_pkg::REG_DIR_SIZE:   m_dir_size = value;
         default: ;
      endcase
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         note_mismatch($sformatf("register %0d read %h, written %h", idx, prdata, value));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // One register setting: build a directory, program it, and walk it repeatedly.
   task automatic run_random_phase();
      logic [31:0] ld, img, off, dsize, page, blen, total;
      logic [3:0]  etype;
      logic [15:0] words[$];
      int          flavor, nblk, nent, goal, cut, pick;
      settle_idle();
      total = '0;
      nblk = $urandom_range(1, 3);
      for (int b = 0; b < nblk; b++) begin
         page = ($urandom_range(0, 5) == 0) ? $urandom : ($urandom & 32'h00FF_F000);
         nent = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
         blen = brsp_pkg::HEADER_BYTES + 2 * nent;
         total = total + blen;
         // Now and then a block size that is too small, odd or too large.
         pick = $urandom_range(0, 15);
         if (pick == 0) blen = $urandom_range(0, 7);
         else if (pick == 1) blen = blen + 1;
         else if (pick == 2) blen = blen + 32'h0001_0000;
         words.insert(words.size(), page[15:0]);
         words.insert(words.size(), page[31:16]);
         words.insert(words.size(), blen[15:0]);
         words.insert(words.size(), blen[31:16]);
         for (int e = 0; e < nent; e++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               etype = brsp_pkg::TYPE_HIGHLOW;
            end else if (pick < 9) begin
               etype = brsp_pkg::TYPE_SKIP;
            end else begin
               etype = 4'($urandom);
               if (etype == brsp_pkg::TYPE_SKIP || etype == brsp_pkg::TYPE_HIGHLOW) begin
                  etype = 4'hF;
               end
            end
            words.insert(words.size(), {etype, 12'($urandom)});
         end
      end

      ld = $urandom & 32'h7FFF_F000;
      img = $urandom;
      if (img == ld) img = ~ld;
      off = $urandom_range(1, 32'h000F_FFFF);
      dsize = total;
      pick = $urandom_range(0, 7);
      if (pick == 0) dsize = total + $urandom_range(1, 12);
      else if (pick == 1 && total > brsp_pkg::HEADER_BYTES) dsize = total - 2;
      flavor = $urandom_range(0, 9);
      case (flavor)
         0: img = ld;
         1: begin
            ld = 32'hFFFF_FFFF;
            img = 32'h0000_0000;
         end
         2: begin
            ld = 32'h0000_0000;
            img = 32'hFFFF_FFFF;
            off = 32'hFFFF_FFFF;
         end
         3: begin
            if ($urandom_range(0, 1)) off = '0;
            else dsize = '0;
         end
         4: dsize = 32'hFFFF_FFFF;
         default: ;
      endcase
      write_reg(brsp_pkg::REG_LOAD_BASE, ld);
      write_reg(brsp_pkg::REG_IMAGE_BASE, img);
      write_reg(brsp_pkg::REG_DIR_OFFSET, off);
      write_reg(brsp_pkg::REG_DIR_SIZE, dsize);
      settings_count++;

      // Mostly whole passes, some cut short, with stray items in between.
      sender_steady = ($urandom_range(0, 3) == 0);
      goal = items_sent + $urandom_range(30, 60);
      while (items_sent < goal) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, words.size()) : words.size();
            in_pass = 1'b1;
            send_item({brsp_pkg::OP_START, 16'($urandom)}, 1'b0, '0);
            for (int w = 0; w < cut; w++) send_item({brsp_pkg::OP_HALF, words[w]}, 1'b0, '0);
            in_pass = 1'b0;
         end else if (pick < 19) begin
            repeat ($urandom_range(1, 4)) begin
               send_item({1'($urandom_range(0, 1)), 16'($urandom)}, 1'b0, '0);
            end
         end else begin
            send_item({brsp_pkg::OP_START, 16'($urandom)}, 1'b0, '0);
         end
      end
      sender_steady = 1'b0;
   endtask

   // Check each result transfer against the oldest outstanding prediction.
   always @(posedge clock) begin
      brsp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reloc_results_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result %h", rsp_payload));
         end else begin
            want = reloc_results_q.pop_front();
            if (rsp_payload.kind !== want.kind)
               note_mismatch($sformatf("kind %0d, want %0d", rsp_payload.kind, want.kind));
            if (rsp_payload.target_address !== want.target_address)
               note_mismatch($sformatf("target %h, want %h", rsp_payload.target_address,
                                       want.target_address));
            if (rsp_payload.error_code !== want.error_code)
               note_mismatch($sformatf("error code %0d, want %0d", rsp_payload.error_code,
                                       want.error_code));
            if (rsp_payload.last !== want.last)
               note_mismatch($sformatf("last %b, want %b", rsp_payload.last, want.last));
         end
         case (rsp_payload.kind)
            brsp_pkg::KIND_FIXUP:    n_fixup++;
            brsp_pkg::KIND_FINISHED: n_finished++;
            default:                 n_error++;
         endcase
      end
   end

   // Receiver: random stalls, and long hold-offs in the middle of a pass until the
   // input has been seen to stall behind a full block.
   initial begin
      int  run_len;
      int  gap;
      bit  held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
         repeat (run_len) @(posedge clock);
         if (!held && in_pass && live_items >= 60) begin
            rsp_ready <= 1'b0;
            for (int c = 0; c < HOLD_OFF_CYCLES; c++) begin
               @(posedge clock);
               if (req_valid && !req_ready) held = 1'b1;
            end
         end else begin
            gap = pick_gap();
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Main sequence: reset, directed table, random settings, drain and verdict.
   initial begin
      int target;
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
            settle_idle();
            write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value);
         end else begin
            send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].pinned,
                      DIRECTED_ROWS[i].outcome);
         end
      end
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) run_random_phase();

      req_valid <= 1'b0;
      for (n = 0; n < DRAIN_LIMIT && reloc_results_q.size() != 0; n++) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (reloc_results_q.size() != 0) begin
         note_mismatch($sformatf("%0d predicted results never arrived", reloc_results_q.size()));
      end
      $display("Run covered %0d item transfers (%0d acted on) over %0d random register settings.",
               items_sent, live_items, settings_count);
      $display("Results seen: %0d fixups, %0d finished marks, %0d errors; %0d mismatches.",
               n_fixup, n_finished, n_error, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

endmodule
